### rtl/core/rtpe_pkg.sv
// Shared types and constants for the ring ternary pattern extractor.
// Used by every file in rtl/core; depends on nothing.
`timescale 1ns / 1ps

package rtpe_pkg;

  // Window and ring geometry
  localparam int WIN         = 7;
  localparam int LINES       = 6;
  localparam int RING_POINTS = 16;
  localparam int CENTRE_OFS  = 3;
  localparam int EMIT_MIN    = 6;
  localparam int MIN_WIDTH   = 7;

  // Field widths
  localparam int PIX_W   = 8;
  localparam int THR_W   = 8;
  localparam int IWID_W  = 11;
  localparam int COL_W   = 10;
  localparam int ROW_W   = 12;
  localparam int CODE_W  = 32;
  localparam int WCMP_W  = 13;   // holds any row width up to 4096

  localparam logic [ROW_W-1:0] ROW_MAX = 12'd4095;

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 11;
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH = 2'd1;

  // Result queue
  localparam int OUTQ_DEPTH = 4;
  localparam int OUTQ_AW    = 2;
  localparam int OUTQ_LW    = 3;

  // Ring offsets: dx along a row (window column), dy across rows
  localparam int RING_DX [RING_POINTS] =
    '{0, 1, 2, 3, 3, 3, 2, 1, 0, -1, -2, -3, -3, -3, -2, -1};
  localparam int RING_DY [RING_POINTS] =
    '{3, 3, 2, 1, 0, -1, -2, -3, -3, -3, -2, -1, 0, 1, 2, 3};

  typedef enum logic [1:0] {
    CODE_BRIGHTER = 2'd0,
    CODE_DARKER   = 2'd1,
    CODE_SIMILAR  = 2'd2
  } tcode_t;

  typedef logic [PIX_W-1:0]             pixel_t;
  typedef logic [COL_W-1:0]             col_t;
  typedef logic [ROW_W-1:0]             row_t;
  typedef logic [LINES-1:0][PIX_W-1:0]  line_col_t;   // element 0 = oldest row
  typedef logic [WIN-1:0][PIX_W-1:0]    win_col_t;    // element 6 = newest row

  // New window column handed from the line buffer to the window
  typedef struct packed {
    logic     valid;
    win_col_t pixels;
  } col_xfer_t;

  typedef struct packed {
    logic [CODE_W-1:0] ring_code;
    col_t              centre_column;
    row_t              centre_row;
  } result_t;

  typedef struct packed {
    logic    valid;
    result_t res;
  } push_t;

  // Position of a pixel in flight
  typedef struct packed {
    logic valid;
    logic emit;
    col_t col;
    row_t row;
  } stage_t;

endpackage

### rtl/core/rtpe_pixel_if.sv
// Pixel input channel: valid/ready handshake with pixel and frame_start.
// Depends on rtpe_pkg.
`timescale 1ns / 1ps

interface rtpe_pixel_if;
  logic                        valid;
  logic                        ready;
  logic [rtpe_pkg::PIX_W-1:0]  pixel;
  logic                        frame_start;

  modport source (output valid, pixel, frame_start, input ready);
  modport sink   (input valid, pixel, frame_start, output ready);
endinterface

### rtl/core/rtpe_result_if.sv
// Result channel: valid/ready handshake with ring code and centre position.
// Depends on rtpe_pkg.
`timescale 1ns / 1ps

interface rtpe_result_if;
  logic                         valid;
  logic                         ready;
  logic [rtpe_pkg::CODE_W-1:0]  ring_code;
  logic [rtpe_pkg::COL_W-1:0]   centre_column;
  logic [rtpe_pkg::ROW_W-1:0]   centre_row;

  modport source (output valid, ring_code, centre_column, centre_row, input ready);
  modport sink   (input valid, ring_code, centre_column, centre_row, output ready);
endinterface

### rtl/core/ring_ternary_pattern_extract.sv
// Top level of the ring ternary pattern extractor: position counters,
// configuration registers and pipeline control. Depends on rtpe_pkg, the two
// channel interfaces, rtpe_linebuf, rtpe_window and rtpe_outq.
//
// Usage:
//   in_pix  : one grey pixel per transfer in raster order; frame_start marks
//             row 0, column 0 of a frame and restarts the position counters.
//   out_res : one 16-point ternary ring code per centre pixel that lies at
//             least three pixels inside the image, with its column and row.
//   cfg_*   : write threshold (index 0) and image_width (index 1) while idle.
// Throughput: one pixel per clock while in_pix.ready is high. The line buffer
//   word of the pixel's column is read at the transfer and written back the
//   next cycle, so a pixel can follow in every cycle; a same-column revisit
//   is forwarded. Path: a result is offered once its pixel has passed the
//   line memory read, the window update and then the result queue.
// Reset: counters at zero, threshold 10, image_width 640. Line memory is not
//   cleared; the first six rows after reset give no result.
// Stall: a four-entry result queue absorbs a stalled receiver; in_pix.ready
//   drops once the queue plus results still in the pipeline fill it.
`timescale 1ns / 1ps

module ring_ternary_pattern_extract #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  rtpe_pixel_if.sink                           in_pix,
  rtpe_result_if.source                        out_res,
  input  logic                                 cfg_we,
  input  logic [rtpe_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [rtpe_pkg::CFG_DATA_W-1:0]      cfg_wdata
);

  localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

  logic [rtpe_pkg::THR_W-1:0]  threshold_r;
  logic [rtpe_pkg::IWID_W-1:0] image_width_r;
  logic [AW-1:0]               col_r;
  logic [AW-1:0]               col_nxt;
  rtpe_pkg::row_t              row_r;
  rtpe_pkg::row_t              row_nxt;
  logic [AW-1:0]               col_eff;
  rtpe_pkg::row_t              row_eff;
  logic [rtpe_pkg::WCMP_W-1:0] act_width;
  logic                        wrap;
  logic                        accept;
  logic                        emit;
  logic [AW-1:0]               col_m3;
  rtpe_pkg::stage_t            s1_r;
  rtpe_pkg::stage_t            s2_r;
  rtpe_pkg::stage_t            s0;
  rtpe_pkg::col_xfer_t         col_x;
  rtpe_pkg::push_t             push;
  logic [rtpe_pkg::CODE_W-1:0] ring_code;
  logic [rtpe_pkg::OUTQ_LW-1:0] level;
  logic [rtpe_pkg::OUTQ_LW-1:0] pending;

  assign accept = in_pix.valid && in_pix.ready;

  // Results already committed: queued plus in the two pipeline stages
  assign pending = level
                 + rtpe_pkg::OUTQ_LW'(s1_r.valid && s1_r.emit)
                 + rtpe_pkg::OUTQ_LW'(s2_r.valid && s2_r.emit);
  assign in_pix.ready = (pending < rtpe_pkg::OUTQ_LW'(rtpe_pkg::OUTQ_DEPTH));

  // Position of the incoming pixel
  assign col_eff = in_pix.frame_start ? '0 : col_r;
  assign row_eff = in_pix.frame_start ? '0 : row_r;

  // Row width clamped to at least seven and to what the line memory holds
  always_comb begin
    act_width = rtpe_pkg::WCMP_W'(image_width_r);
    if (act_width < rtpe_pkg::WCMP_W'(rtpe_pkg::MIN_WIDTH)) begin
      act_width = rtpe_pkg::WCMP_W'(rtpe_pkg::MIN_WIDTH);
    end else if (act_width > rtpe_pkg::WCMP_W'(MAX_WIDTH)) begin
      act_width = rtpe_pkg::WCMP_W'(MAX_WIDTH);
    end
  end

  assign wrap = (rtpe_pkg::WCMP_W'(col_eff) + 1'b1) >= act_width;

  always_comb begin
    col_nxt = col_eff + 1'b1;
    row_nxt = row_eff;
    if (wrap) begin
      col_nxt = '0;
      if (row_eff != rtpe_pkg::ROW_MAX) begin
        row_nxt = row_eff + 1'b1;
      end
    end
  end

  // Centre sits three back in both directions
  assign emit   = (row_eff >= rtpe_pkg::row_t'(rtpe_pkg::EMIT_MIN)) &&
                  (rtpe_pkg::WCMP_W'(col_eff) >= rtpe_pkg::WCMP_W'(rtpe_pkg::EMIT_MIN));
  assign col_m3 = col_eff - AW'(rtpe_pkg::CENTRE_OFS);

  always_comb begin
    s0.valid = accept;
    s0.emit  = emit;
    s0.col   = rtpe_pkg::col_t'(col_m3);
    s0.row   = row_eff - rtpe_pkg::row_t'(rtpe_pkg::CENTRE_OFS);
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      threshold_r   <= 8'd10;
      image_width_r <= 11'd640;
    end else if (cfg_we) begin
      unique case (cfg_index)
        rtpe_pkg::REG_THRESHOLD:   threshold_r   <= cfg_wdata[rtpe_pkg::THR_W-1:0];
        rtpe_pkg::REG_IMAGE_WIDTH: image_width_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Position counters and stage tracking
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
      s1_r  <= '0;
      s2_r  <= '0;
    end else begin
      if (accept) begin
        col_r <= col_nxt;
        row_r <= row_nxt;
      end
      s1_r <= s0;
      s2_r <= s1_r;
    end
  end

  rtpe_linebuf #(
    .MAX_WIDTH (MAX_WIDTH),
    .AW        (AW)
  ) u_linebuf (
    .clk      (clk),
    .rst_n    (rst_n),
    .rd_en    (accept),
    .rd_addr  (col_eff),
    .pixel_in (in_pix.pixel),
    .col_o    (col_x)
  );

  rtpe_window u_window (
    .clk       (clk),
    .rst_n     (rst_n),
    .col_i     (col_x),
    .threshold (threshold_r),
    .ring_code (ring_code)
  );

  // Window now holds the s2 pixel's neighborhood
  always_comb begin
    push.valid             = s2_r.valid && s2_r.emit;
    push.res.ring_code     = ring_code;
    push.res.centre_column = s2_r.col;
    push.res.centre_row    = s2_r.row;
  end

  rtpe_outq u_outq (
    .clk     (clk),
    .rst_n   (rst_n),
    .push_i  (push),
    .out_res (out_res),
    .level_o (level)
  );

`ifndef NO_ASSERTIONS
  // An emitted centre is always inside the border
  a_centre_range: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_r.valid && s1_r.emit) |->
      (s1_r.col >= rtpe_pkg::col_t'(rtpe_pkg::CENTRE_OFS)) &&
      (s1_r.row >= rtpe_pkg::row_t'(rtpe_pkg::CENTRE_OFS)) &&
      (s1_r.row <= (rtpe_pkg::ROW_MAX - rtpe_pkg::row_t'(rtpe_pkg::CENTRE_OFS))))
    else $error("result centre outside the image interior");

  // Committed results never exceed the queue capacity
  a_credit: assert property (@(posedge clk) disable iff (!rst_n)
    pending <= rtpe_pkg::OUTQ_LW'(rtpe_pkg::OUTQ_DEPTH))
    else $error("more results in flight than queue entries");
`endif

endmodule

### rtl/core/rtpe_linebuf.sv
// Six-row line buffer: one synchronous memory, one 48-bit word per column.
// Read-modify-write per pixel with one-deep forwarding. Depends on rtpe_pkg.
`timescale 1ns / 1ps

module rtpe_linebuf #(
  parameter int MAX_WIDTH = 1024,
  parameter int AW        = 10
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                rd_en,
  input  logic [AW-1:0]       rd_addr,
  input  rtpe_pkg::pixel_t    pixel_in,
  output rtpe_pkg::col_xfer_t col_o
);

  rtpe_pkg::line_col_t mem [MAX_WIDTH];

  rtpe_pkg::line_col_t rdata_r;
  rtpe_pkg::line_col_t fwd_data_r;
  rtpe_pkg::line_col_t cur;
  rtpe_pkg::line_col_t wr_data;
  rtpe_pkg::pixel_t    s1_pixel_r;
  logic [AW-1:0]       s1_addr_r;
  logic                s1_valid_r;
  logic                fwd_r;
  logic                fwd_nxt;

  // Column word as seen after the previous pixel's write
  assign cur     = fwd_r ? fwd_data_r : rdata_r;
  // Rows move up by one, new pixel becomes the youngest stored row
  assign wr_data = {s1_pixel_r, cur[rtpe_pkg::LINES-1:1]};

  // Same column read while its update is being written
  assign fwd_nxt = rd_en && s1_valid_r && (rd_addr == s1_addr_r);

  assign col_o.valid  = s1_valid_r;
  assign col_o.pixels = {s1_pixel_r, cur};

  // Line memory: write port at stage 1, read port at accept
  always_ff @(posedge clk) begin
    if (s1_valid_r) begin
      mem[s1_addr_r] <= wr_data;
    end
    if (rd_en) begin
      rdata_r <= mem[rd_addr];
    end
  end

  // Stage payload
  always_ff @(posedge clk) begin
    if (rd_en) begin
      s1_pixel_r <= pixel_in;
      s1_addr_r  <= rd_addr;
    end
    fwd_data_r <= wr_data;
  end

  // Stage control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      fwd_r      <= 1'b0;
    end else begin
      s1_valid_r <= rd_en;
      fwd_r      <= fwd_nxt;
    end
  end

endmodule

### rtl/core/rtpe_window.sv
// 7x7 pixel window and the sixteen ring comparators.
// Depends on rtpe_pkg.
`timescale 1ns / 1ps

module rtpe_window (
  input  logic                           clk,
  input  logic                           rst_n,
  input  rtpe_pkg::col_xfer_t            col_i,
  input  logic [rtpe_pkg::THR_W-1:0]     threshold,
  output logic [rtpe_pkg::CODE_W-1:0]    ring_code
);

  // win_r[column][row], column 6 newest
  rtpe_pkg::win_col_t win_r [rtpe_pkg::WIN];

  logic signed [rtpe_pkg::PIX_W+1:0] centre;
  logic signed [rtpe_pkg::PIX_W+1:0] thr_s;
  logic signed [rtpe_pkg::PIX_W+1:0] hi;
  logic signed [rtpe_pkg::PIX_W+1:0] lo;

  // Shift left one column per transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int c = 0; c < rtpe_pkg::WIN; c++) begin
        win_r[c] <= '0;
      end
    end else if (col_i.valid) begin
      for (int c = 0; c < rtpe_pkg::WIN - 1; c++) begin
        win_r[c] <= win_r[c+1];
      end
      win_r[rtpe_pkg::WIN-1] <= col_i.pixels;
    end
  end

  // Ten-bit signed bounds never wrap
  assign centre = signed'({2'b00, win_r[rtpe_pkg::CENTRE_OFS][rtpe_pkg::CENTRE_OFS]});
  assign thr_s  = signed'({2'b00, threshold});
  assign hi     = centre + thr_s;
  assign lo     = centre - thr_s;

  // One comparator pair per ring point
  for (genvar i = 0; i < rtpe_pkg::RING_POINTS; i++) begin : g_ring
    localparam int C = rtpe_pkg::CENTRE_OFS + rtpe_pkg::RING_DX[i];
    localparam int R = rtpe_pkg::CENTRE_OFS + rtpe_pkg::RING_DY[i];
    logic signed [rtpe_pkg::PIX_W+1:0] p;
    assign p = signed'({2'b00, win_r[C][R]});
    assign ring_code[2*i +: 2] = (p > hi) ? rtpe_pkg::CODE_BRIGHTER :
                                 (p < lo) ? rtpe_pkg::CODE_DARKER   :
                                            rtpe_pkg::CODE_SIMILAR;
  end

endmodule

### rtl/core/rtpe_outq.sv
// Four-entry result queue that decouples the pipeline from a stalling receiver.
// Depends on rtpe_pkg and rtpe_result_if.
`timescale 1ns / 1ps

module rtpe_outq (
  input  logic                              clk,
  input  logic                              rst_n,
  input  rtpe_pkg::push_t                   push_i,
  rtpe_result_if.source                     out_res,
  output logic [rtpe_pkg::OUTQ_LW-1:0]      level_o
);

  rtpe_pkg::result_t q_r [rtpe_pkg::OUTQ_DEPTH];

  logic [rtpe_pkg::OUTQ_AW-1:0] wr_ptr_r;
  logic [rtpe_pkg::OUTQ_AW-1:0] rd_ptr_r;
  logic [rtpe_pkg::OUTQ_LW-1:0] level_r;
  logic [rtpe_pkg::OUTQ_LW-1:0] level_nxt;
  logic                         pop;
  rtpe_pkg::result_t            head;

  assign pop     = out_res.valid && out_res.ready;
  assign head    = q_r[rd_ptr_r];
  assign level_o = level_r;

  assign out_res.valid         = (level_r != '0);
  assign out_res.ring_code     = head.ring_code;
  assign out_res.centre_column = head.centre_column;
  assign out_res.centre_row    = head.centre_row;

  always_comb begin
    level_nxt = level_r;
    if (push_i.valid && !pop) begin
      level_nxt = level_r + 1'b1;
    end else if (!push_i.valid && pop) begin
      level_nxt = level_r - 1'b1;
    end
  end

  // Entry storage
  always_ff @(posedge clk) begin
    if (push_i.valid) begin
      q_r[wr_ptr_r] <= push_i.res;
    end
  end

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      level_r  <= '0;
    end else begin
      if (push_i.valid) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      level_r <= level_nxt;
    end
  end

`ifndef NO_ASSERTIONS
  // Credit check upstream must keep the queue from overflowing
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(push_i.valid && !pop && (level_r == rtpe_pkg::OUTQ_LW'(rtpe_pkg::OUTQ_DEPTH))))
    else $error("result queue overflow");

  // Pointer distance tracks the level
  a_ptr_level: assert property (@(posedge clk) disable iff (!rst_n)
    (wr_ptr_r - rd_ptr_r) == level_r[rtpe_pkg::OUTQ_AW-1:0])
    else $error("result queue pointers disagree with level");
`endif

endmodule
